FILE: rtl/qmm_pkg.sv
// Package for the quad motor mixer: widths, register codes, shared types.
package qmm_pkg;

	// Field widths
	localparam int STICK_W  = 12;
	localparam int HRATE_W  = 12;
	localparam int RATE_W   = 11;
	localparam int LEVEL_W  = 10;
	localparam int PWM_W    = 11;
	localparam int MOTOR_W  = 14;
	localparam int BASE_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int NUM_MOTORS = 4;

	// Upper clamp applied to each motor before the PWM offset
	localparam logic [LEVEL_W-1:0] PWM_CLAMP_MAX = LEVEL_W'(1000);

	// Register reset values
	localparam logic [STICK_W-1:0] ARM_THRESHOLD_RST    = STICK_W'(1100);
	localparam logic [STICK_W-1:0] CUTOFF_THRESHOLD_RST = STICK_W'(1020);
	localparam logic [STICK_W-1:0] THROTTLE_ZERO_RST    = STICK_W'(1000);
	localparam logic [LEVEL_W-1:0] HOVER_OFFSET_RST     = LEVEL_W'(500);
	localparam logic [LEVEL_W-1:0] BASE_CEILING_RST     = LEVEL_W'(900);
	localparam logic [LEVEL_W-1:0] PWM_OFFSET_RST       = LEVEL_W'(0);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ARM_THRESHOLD    = 3'd0,
		CFG_CUTOFF_THRESHOLD = 3'd1,
		CFG_THROTTLE_ZERO    = 3'd2,
		CFG_HOVER_OFFSET     = 3'd3,
		CFG_BASE_CEILING     = 3'd4,
		CFG_PWM_OFFSET       = 3'd5
	} cfg_idx_t;

	// Arming phase
	typedef enum logic [1:0] {
		PH_WAIT  = 2'd0,
		PH_ARMED = 2'd1,
		PH_FLY   = 2'd2
	} phase_t;

	typedef logic signed [MOTOR_W-1:0] motor_t;
	typedef logic [PWM_W-1:0] pwm_t;

	typedef struct packed {
		logic [STICK_W-1:0] arm_threshold;
		logic [STICK_W-1:0] cutoff_threshold;
		logic [STICK_W-1:0] throttle_zero;
		logic [LEVEL_W-1:0] hover_offset;
		logic [LEVEL_W-1:0] base_ceiling;
		logic [LEVEL_W-1:0] pwm_offset;
	} cfg_t;

	// One input word
	typedef struct packed {
		logic                      armed;
		logic                      height_hold;
		logic                      liftoff;
		logic [STICK_W-1:0]        throttle_stick;
		logic signed [HRATE_W-1:0] height_rate_cmd;
		logic signed [RATE_W-1:0]  roll_rate_cmd;
		logic signed [RATE_W-1:0]  pitch_rate_cmd;
		logic signed [RATE_W-1:0]  yaw_rate_cmd;
	} item_t;

endpackage

FILE: rtl/qmm_cfg.sv
// Configuration register file of the quad motor mixer.
module qmm_cfg
	import qmm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_threshold    <= ARM_THRESHOLD_RST;
			cfg_q.cutoff_threshold <= CUTOFF_THRESHOLD_RST;
			cfg_q.throttle_zero    <= THROTTLE_ZERO_RST;
			cfg_q.hover_offset     <= HOVER_OFFSET_RST;
			cfg_q.base_ceiling     <= BASE_CEILING_RST;
			cfg_q.pwm_offset       <= PWM_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ARM_THRESHOLD:    cfg_q.arm_threshold    <= cfg_data;
				CFG_CUTOFF_THRESHOLD: cfg_q.cutoff_threshold <= cfg_data;
				CFG_THROTTLE_ZERO:    cfg_q.throttle_zero    <= cfg_data;
				CFG_HOVER_OFFSET:     cfg_q.hover_offset     <= cfg_data[LEVEL_W-1:0];
				CFG_BASE_CEILING:     cfg_q.base_ceiling     <= cfg_data[LEVEL_W-1:0];
				CFG_PWM_OFFSET:       cfg_q.pwm_offset       <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/qmm_mix.sv
// Arming phase logic, base throttle, X-frame mixing and PWM clamp for one word.
module qmm_mix
	import qmm_pkg::*;
(
	input  cfg_t   cfg,
	input  item_t  item,
	input  phase_t phase_q,
	input  motor_t motor_q [NUM_MOTORS],
	output phase_t phase_d,
	output motor_t motor_d [NUM_MOTORS],
	output pwm_t   pwm [NUM_MOTORS]
);

	logic                     stick_above_arm;
	logic                     stick_below_cut;
	logic signed [BASE_W-1:0] base_raw;
	logic [LEVEL_W-1:0]       base;
	motor_t                   b_m, r_m, p_m, y_m;
	motor_t                   mix [NUM_MOTORS];

	assign stick_above_arm = item.throttle_stick > cfg.arm_threshold;
	assign stick_below_cut = item.throttle_stick < cfg.cutoff_threshold;

	// Next phase
	always_comb begin
		if (!item.armed) begin
			phase_d = PH_WAIT;
		end else begin
			unique case (phase_q)
				PH_ARMED: phase_d = stick_above_arm ? PH_FLY : PH_ARMED;
				PH_FLY:   phase_d = PH_FLY;
				default:  phase_d = stick_above_arm ? PH_FLY : PH_ARMED;
			endcase
		end
	end

	// Base throttle: height hold or manual stick, then clamp to 0..ceiling
	always_comb begin
		if (item.height_hold)
			base_raw = BASE_W'(item.height_rate_cmd) + $signed({3'b000, cfg.hover_offset});
		else
			base_raw = $signed({1'b0, item.throttle_stick}) - $signed({1'b0, cfg.throttle_zero});
		if (base_raw < 0)
			base = '0;
		else if (base_raw > $signed({3'b000, cfg.base_ceiling}))
			base = cfg.base_ceiling;
		else
			base = base_raw[LEVEL_W-1:0];
	end

	// X mixing
	assign b_m = $signed({{(MOTOR_W-LEVEL_W){1'b0}}, base});
	assign r_m = MOTOR_W'(item.roll_rate_cmd);
	assign p_m = MOTOR_W'(item.pitch_rate_cmd);
	assign y_m = MOTOR_W'(item.yaw_rate_cmd);
	assign mix[0] = b_m + r_m - p_m - y_m;
	assign mix[1] = b_m + r_m + p_m + y_m;
	assign mix[2] = b_m - r_m + p_m - y_m;
	assign mix[3] = b_m - r_m - p_m + y_m;

	// Next motor values
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			motor_d[i] = motor_q[i];
			if (!item.armed) begin
				motor_d[i] = '0;
			end else begin
				case (phase_q)
					PH_ARMED: motor_d[i] = motor_q[i];
					PH_FLY: begin
						if (stick_below_cut)
							motor_d[i] = '0;
						else if (item.liftoff)
							motor_d[i] = mix[i];
					end
					default: motor_d[i] = '0;
				endcase
			end
		end
	end

	// PWM: offset plus motor clamped to 0..1000
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			logic [LEVEL_W-1:0] c;
			if (motor_d[i] < 0)
				c = '0;
			else if (motor_d[i] > $signed({{(MOTOR_W-LEVEL_W){1'b0}}, PWM_CLAMP_MAX}))
				c = PWM_CLAMP_MAX;
			else
				c = motor_d[i][LEVEL_W-1:0];
			pwm[i] = {1'b0, c} + {1'b0, cfg.pwm_offset};
		end
	end

endmodule

FILE: rtl/quad_motor_mixer_with_arming.sv
// Top level of the quad motor mixer: input register, mixer, state and result register.
//
// Each word (flags, throttle stick, height and rate commands) is taken into an
// input register, mixed combinationally into four PWM values and the arming phase,
// and held in a result register until the sink takes it; the arming phase and
// the four motor values are updated as the word moves into the result register.
// A word passes from the input register to the result register unless the
// output stall holds it in the input register, and one word is accepted every
// cycle while the output is not stalled; the rate is set by the phase and motor
// update, whose result feeds the next word. Configuration is to be written
// through cfg_we/cfg_index/cfg_data while no word is in flight; the block does
// not enforce this, and writes to indexes past the register list are ignored.
module quad_motor_mixer_with_arming
	import qmm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      armed,
	input  logic                      height_hold,
	input  logic                      liftoff,
	input  logic [STICK_W-1:0]        throttle_stick,
	input  logic signed [HRATE_W-1:0] height_rate_cmd,
	input  logic signed [RATE_W-1:0]  roll_rate_cmd,
	input  logic signed [RATE_W-1:0]  pitch_rate_cmd,
	input  logic signed [RATE_W-1:0]  yaw_rate_cmd,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PWM_W-1:0]          pwm_front_a,
	output logic [PWM_W-1:0]          pwm_front_b,
	output logic [PWM_W-1:0]          pwm_rear_a,
	output logic [PWM_W-1:0]          pwm_rear_b,
	output logic [1:0]                phase
);

	cfg_t   cfg;
	logic   valid_s1;
	item_t  item_s1;
	logic   valid_s2;
	pwm_t   pwm_s2 [NUM_MOTORS];
	phase_t phase_s2;
	phase_t phase_q;
	motor_t motor_q [NUM_MOTORS];
	phase_t phase_d;
	motor_t motor_d [NUM_MOTORS];
	pwm_t   pwm_d [NUM_MOTORS];
	logic   advance;
	logic   in_take;

	qmm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qmm_mix u_mix (
		.cfg     (cfg),
		.item    (item_s1),
		.phase_q (phase_q),
		.motor_q (motor_q),
		.phase_d (phase_d),
		.motor_d (motor_d),
		.pwm     (pwm_d)
	);

	// Handshake: s1 moves on when the result register is empty or being taken
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take || advance)
			valid_s1 <= in_take;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.armed           <= armed;
			item_s1.height_hold     <= height_hold;
			item_s1.liftoff         <= liftoff;
			item_s1.throttle_stick  <= throttle_stick;
			item_s1.height_rate_cmd <= height_rate_cmd;
			item_s1.roll_rate_cmd   <= roll_rate_cmd;
			item_s1.pitch_rate_cmd  <= pitch_rate_cmd;
			item_s1.yaw_rate_cmd    <= yaw_rate_cmd;
		end
	end

	// Phase and motor state, updated as each word is mixed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			for (int i = 0; i < NUM_MOTORS; i++)
				motor_q[i] <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			for (int i = 0; i < NUM_MOTORS; i++)
				motor_q[i] <= motor_d[i];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2 <= phase_d;
			for (int i = 0; i < NUM_MOTORS; i++)
				pwm_s2[i] <= pwm_d[i];
		end
	end

	assign out_valid   = valid_s2;
	assign pwm_front_a = pwm_s2[0];
	assign pwm_front_b = pwm_s2[1];
	assign pwm_rear_a  = pwm_s2[2];
	assign pwm_rear_b  = pwm_s2[3];
	assign phase       = phase_s2;

	// Motors can only hold nonzero values while flying
	a_motor_zero_unless_flying: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_FLY) |-> (motor_q[0] == 0 && motor_q[1] == 0 &&
			motor_q[2] == 0 && motor_q[3] == 0))
		else $error("motor value nonzero outside flying phase");

	// A disarmed word yields phase wait and bare offset; checked on front_a and rear_b
	a_disarm_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.armed) |=> (out_valid && phase == PH_WAIT &&
			pwm_front_a == PWM_W'($past(cfg.pwm_offset)) &&
			pwm_rear_b == PWM_W'($past(cfg.pwm_offset))))
		else $error("disarmed word did not zero motors");

	// Input only stalls while a word sits blocked in the input register
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked word");

	// The state register follows the phase just reported
	a_phase_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (phase_s2 == phase_q))
		else $error("reported phase differs from state");

endmodule
